// ===== rtl/mch_pkg.sv =====
package mch_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int SCALE_FRAC_BITS = 12;

    localparam int ANGLE_TABLE_LEN = 24;
    localparam int CORDIC_ITERS    = (CORDIC_STEPS < ANGLE_TABLE_LEN) ?
                                     CORDIC_STEPS : ANGLE_TABLE_LEN;
    localparam int ITER_W          = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
    localparam int ANG_W           = 30;
    localparam int VEC_W           = 36;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam logic signed [ANG_W-1:0] DEG180_UNITS = 30'sd73728000;
    localparam logic signed [ANG_W-1:0] DEG360_UNITS = 30'sd147456000;
    localparam int FULL_CIRCLE     = 36000;

    localparam int SPAN_W  = 17;
    localparam int SUM_W   = 18;
    localparam int DIV_W   = SPAN_W + 2;
    localparam int NUM_W   = SUM_W + SCALE_FRAC_BITS;
    localparam int DCNT_W  = $clog2(NUM_W);
    localparam int D2_W    = 18;
    localparam int PROD_W  = 35;
    localparam int PSHIFT  = SCALE_FRAC_BITS + 1;

    localparam logic [15:0] SCALE_ONE = 16'(1 << SCALE_FRAC_BITS);

    typedef enum logic [1:0] {
        MODE_MEASURE = 2'd0,
        MODE_CLEAR   = 2'd1,
        MODE_SAMPLE  = 2'd2,
        MODE_FINISH  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_MEASURED   = 3'd0,
        ST_CLEARED    = 3'd1,
        ST_SAMPLED    = 3'd2,
        ST_DONE       = 3'd3,
        ST_DONE_DEGEN = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CFG_X_SOURCE    = 3'd0,
        CFG_Y_SOURCE    = 3'd1,
        CFG_Z_SOURCE    = 3'd2,
        CFG_INVERT_MASK = 3'd3,
        CFG_DECLINATION = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        LOP_NONE,
        LOP_LOAD,
        LOP_CALC,
        LOP_SCALE,
        LOP_DIV_START,
        LOP_DIV_STEP,
        LOP_DIV_END
    } t_lane_op;

    typedef struct packed {
        t_lane_op op;
        t_mode    mode;
        logic     cal_valid;
    } t_lane_ctrl;

    function automatic logic signed [ANG_W-1:0] atan_units(input logic [4:0] idx);
        logic signed [ANG_W-1:0] r;
        unique case (idx)
            5'd0:  r = 30'sd18432000;
            5'd1:  r = 30'sd10881045;
            5'd2:  r = 30'sd5749245;
            5'd3:  r = 30'sd2918407;
            5'd4:  r = 30'sd1464867;
            5'd5:  r = 30'sd733147;
            5'd6:  r = 30'sd366663;
            5'd7:  r = 30'sd183343;
            5'd8:  r = 30'sd91673;
            5'd9:  r = 30'sd45837;
            5'd10: r = 30'sd22918;
            5'd11: r = 30'sd11459;
            5'd12: r = 30'sd5730;
            5'd13: r = 30'sd2865;
            5'd14: r = 30'sd1432;
            5'd15: r = 30'sd716;
            5'd16: r = 30'sd358;
            5'd17: r = 30'sd179;
            5'd18: r = 30'sd90;
            5'd19: r = 30'sd45;
            5'd20: r = 30'sd22;
            5'd21: r = 30'sd11;
            5'd22: r = 30'sd6;
            5'd23: r = 30'sd3;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mch_lane.sv =====
module mch_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mch_pkg::t_lane_ctrl           i_ctrl,
    input  logic [1:0]                    i_src,
    input  logic                          i_neg,
    input  logic signed [15:0]            i_raw_x,
    input  logic signed [15:0]            i_raw_y,
    input  logic signed [15:0]            i_raw_z,
    input  logic [mch_pkg::SUM_W-1:0]     i_span_sum,
    output logic signed [15:0]            o_res,
    output logic [mch_pkg::SPAN_W-1:0]    o_span
);

    logic signed [15:0]                   n_v;
    logic signed [15:0]                   r_v;
    logic signed [15:0]                   r_min;
    logic signed [15:0]                   r_max;
    logic signed [16:0]                   r_off;
    logic [15:0]                          r_scale;
    logic signed [mch_pkg::PROD_W-1:0]    r_prod;
    logic signed [15:0]                   r_res;
    logic [mch_pkg::SPAN_W-1:0]           r_span;
    logic [mch_pkg::DIV_W-1:0]            r_div;
    logic [mch_pkg::DIV_W-1:0]            r_rem;
    logic [mch_pkg::NUM_W-1:0]            r_num;

    logic signed [15:0]                   sel;
    logic signed [mch_pkg::D2_W-1:0]      d2;
    logic signed [mch_pkg::PROD_W-1:0]    prod;
    logic signed [mch_pkg::PROD_W-1:0]    prod_adj;
    logic signed [mch_pkg::PROD_W-1:0]    prod_sh;
    logic signed [15:0]                   cal;
    logic signed [16:0]                   diff;
    logic [mch_pkg::DIV_W-1:0]            trial;
    logic                                 fits;

    always_comb begin
        unique case (i_src)
            2'd0:    sel = i_raw_x;
            2'd1:    sel = i_raw_y;
            default: sel = i_raw_z;
        endcase
        if (i_neg) begin
            n_v = (sel == -16'sd32768) ? 16'sd32767 : -sel;
        end else begin
            n_v = sel;
        end

        d2   = ($signed({{2{r_v[15]}}, r_v}) <<< 1) - mch_pkg::D2_W'(r_off);
        prod = mch_pkg::PROD_W'(d2) * $signed({{(mch_pkg::PROD_W-16){1'b0}}, r_scale});

        prod_adj = r_prod + ((r_prod < 0) ?
                   mch_pkg::PROD_W'((1 << mch_pkg::PSHIFT) - 1) : '0);
        prod_sh  = prod_adj >>> mch_pkg::PSHIFT;
        if (prod_sh > 32767) begin
            cal = 16'sd32767;
        end else if (prod_sh < -32768) begin
            cal = -16'sd32768;
        end else begin
            cal = prod_sh[15:0];
        end

        diff  = $signed({r_max[15], r_max}) - $signed({r_min[15], r_min});
        trial = {r_rem[mch_pkg::DIV_W-2:0], r_num[mch_pkg::NUM_W-1]};
        fits  = (trial >= r_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= 16'sd32767;
            r_max   <= -16'sd32768;
            r_off   <= '0;
            r_scale <= mch_pkg::SCALE_ONE;
        end else begin
            unique case (i_ctrl.op)
                mch_pkg::LOP_LOAD: begin
                    r_v <= n_v;
                end
                mch_pkg::LOP_CALC: begin
                    unique case (i_ctrl.mode)
                        mch_pkg::MODE_MEASURE: begin
                            r_prod <= prod;
                        end
                        mch_pkg::MODE_CLEAR: begin
                            r_min   <= 16'sd32767;
                            r_max   <= -16'sd32768;
                            r_off   <= '0;
                            r_scale <= mch_pkg::SCALE_ONE;
                        end
                        mch_pkg::MODE_SAMPLE: begin
                            if (r_v < r_min) begin
                                r_min <= r_v;
                            end
                            if (r_v > r_max) begin
                                r_max <= r_v;
                            end
                        end
                        mch_pkg::MODE_FINISH: begin
                            r_span <= (r_max > r_min) ? diff : '0;
                            r_off  <= (r_max < r_min) ? '0 : diff + ($signed({r_min[15], r_min}) <<< 1);
                        end
                        default: ;
                    endcase
                end
                mch_pkg::LOP_SCALE: begin
                    r_res <= i_ctrl.cal_valid ? cal : r_v;
                end
                mch_pkg::LOP_DIV_START: begin
                    r_num <= {i_span_sum, {mch_pkg::SCALE_FRAC_BITS{1'b0}}};
                    r_div <= {1'b0, r_span, 1'b0} + {2'b00, r_span};
                    r_rem <= '0;
                end
                mch_pkg::LOP_DIV_STEP: begin
                    r_rem <= fits ? trial - r_div : trial;
                    r_num <= {r_num[mch_pkg::NUM_W-2:0], fits};
                end
                mch_pkg::LOP_DIV_END: begin
                    if (r_span == '0) begin
                        r_scale <= mch_pkg::SCALE_ONE;
                    end else if (|r_num[mch_pkg::NUM_W-1:16]) begin
                        r_scale <= 16'hFFFF;
                    end else begin
                        r_scale <= r_num[15:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res  = r_res;
    assign o_span = r_span;

endmodule

// ===== rtl/mch_heading.sv =====
module mch_heading (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    output logic               o_done,
    output logic [15:0]        o_heading
);

    typedef enum logic [1:0] {
        H_IDLE,
        H_ROT,
        H_FIN
    } t_hstate;

    t_hstate                             r_state;
    logic                                r_done;
    logic                                r_zero;
    logic [mch_pkg::ITER_W-1:0]          r_i;
    logic signed [mch_pkg::VEC_W-1:0]    r_x;
    logic signed [mch_pkg::VEC_W-1:0]    r_y;
    logic signed [mch_pkg::ANG_W-1:0]    r_ang;
    logic [15:0]                         r_head;

    logic signed [mch_pkg::VEC_W-1:0]    x0;
    logic signed [mch_pkg::VEC_W-1:0]    y0;
    logic signed [mch_pkg::VEC_W-1:0]    xs;
    logic signed [mch_pkg::VEC_W-1:0]    ys;
    logic signed [mch_pkg::ANG_W-1:0]    step_ang;
    logic signed [mch_pkg::ANG_W-1:0]    adj;
    logic signed [mch_pkg::ANG_W-1:0]    rnd;
    logic [mch_pkg::ANG_W-1:0]           q;
    logic [mch_pkg::ANG_W-1:0]           q_wrap;

    always_comb begin
        x0       = $signed({{(mch_pkg::VEC_W-32){i_x[15]}}, i_x, 16'h0000});
        y0       = $signed({{(mch_pkg::VEC_W-32){i_y[15]}}, i_y, 16'h0000});
        xs       = r_x >>> r_i;
        ys       = r_y >>> r_i;
        step_ang = mch_pkg::atan_units(5'(r_i));
        adj      = (r_ang < 0) ? r_ang + mch_pkg::DEG360_UNITS : r_ang;
        rnd      = adj + mch_pkg::ANG_W'(1 << (mch_pkg::ANGLE_FRAC_BITS - 1));
        q        = mch_pkg::ANG_W'(rnd >>> mch_pkg::ANGLE_FRAC_BITS);
        q_wrap   = (q >= mch_pkg::ANG_W'(mch_pkg::FULL_CIRCLE)) ?
                   q - mch_pkg::ANG_W'(mch_pkg::FULL_CIRCLE) : q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_zero <= (i_x == 0) && (i_y == 0);
                        r_i    <= '0;
                        if (i_x < 0) begin
                            r_x   <= -x0;
                            r_y   <= -y0;
                            r_ang <= mch_pkg::DEG180_UNITS;
                        end else begin
                            r_x   <= x0;
                            r_y   <= y0;
                            r_ang <= '0;
                        end
                        r_state <= H_ROT;
                    end
                end
                H_ROT: begin
                    if (r_y >= 0) begin
                        r_x   <= r_x + ys;
                        r_y   <= r_y - xs;
                        r_ang <= r_ang + step_ang;
                    end else begin
                        r_x   <= r_x - ys;
                        r_y   <= r_y + xs;
                        r_ang <= r_ang - step_ang;
                    end
                    if (r_i == mch_pkg::ITER_W'(mch_pkg::CORDIC_ITERS - 1)) begin
                        r_state <= H_FIN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                H_FIN: begin
                    r_head  <= r_zero ? 16'd0 : q_wrap[15:0];
                    r_done  <= 1'b1;
                    r_state <= H_IDLE;
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_heading = r_head;

endmodule

// ===== rtl/magnetometer_calibrate_heading_unit.sv =====
// Magnetometer min-max hard/soft-iron calibration with heading. One transaction
// is taken at a time: a new sample is accepted once the previous one has left
// the working stages, while its result may still wait in the output register.
// Three axis lanes orient the sample and hold the per-axis calibration. A
// measure transaction multiplies, scales, then runs one CORDIC step per cycle
// for 16 steps plus rounding; a finish transaction runs the restoring divider
// in each lane, which retires one quotient bit per cycle over 30 bits. Clear
// and sample transactions update the lanes and go straight to the output stage.
module magnetometer_calibrate_heading_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_sample_x,
    input  logic signed [15:0] i_sample_y,
    input  logic signed [15:0] i_sample_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic [15:0]        o_magnetic_heading,
    output logic [15:0]        o_true_heading,
    output logic               o_is_calibrated,
    output logic [2:0]         o_status,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC,
        S_SCALE,
        S_HSTART,
        S_HEAD,
        S_TRUE,
        S_DSTART,
        S_DIV,
        S_DEND,
        S_OUT
    } t_state;

    t_state                       r_state;
    mch_pkg::t_mode               r_mode;
    logic                         r_cal_valid;
    logic [mch_pkg::DCNT_W-1:0]   r_dcnt;
    logic [15:0]                  r_true;
    logic [1:0]                   r_x_src;
    logic [1:0]                   r_y_src;
    logic [1:0]                   r_z_src;
    logic [2:0]                   r_inv;
    logic signed [15:0]           r_decl;

    logic                         r_o_valid;
    logic signed [15:0]           r_o_x;
    logic signed [15:0]           r_o_y;
    logic signed [15:0]           r_o_z;
    logic [15:0]                  r_o_mag;
    logic [15:0]                  r_o_true;
    logic                         r_o_cal;
    logic [2:0]                   r_o_status;

    mch_pkg::t_lane_ctrl          lane_ctrl;
    mch_pkg::t_lane_op            lane_op;
    logic signed [15:0]           res_x;
    logic signed [15:0]           res_y;
    logic signed [15:0]           res_z;
    logic [mch_pkg::SPAN_W-1:0]   span_x;
    logic [mch_pkg::SPAN_W-1:0]   span_y;
    logic [mch_pkg::SPAN_W-1:0]   span_z;
    logic [mch_pkg::SUM_W-1:0]    span_sum;
    logic                         head_start;
    logic                         head_done;
    logic [15:0]                  head;
    logic signed [17:0]           tsum;
    logic signed [17:0]           twrap;
    logic                         out_free;
    logic                         degen;
    mch_pkg::t_status             n_status;

    always_comb begin
        unique case (r_state)
            S_IDLE:   lane_op = (i_valid) ? mch_pkg::LOP_LOAD : mch_pkg::LOP_NONE;
            S_CALC:   lane_op = mch_pkg::LOP_CALC;
            S_SCALE:  lane_op = mch_pkg::LOP_SCALE;
            S_DSTART: lane_op = mch_pkg::LOP_DIV_START;
            S_DIV:    lane_op = mch_pkg::LOP_DIV_STEP;
            S_DEND:   lane_op = mch_pkg::LOP_DIV_END;
            default:  lane_op = mch_pkg::LOP_NONE;
        endcase
        lane_ctrl.op        = lane_op;
        lane_ctrl.mode      = r_mode;
        lane_ctrl.cal_valid = r_cal_valid;

        span_sum   = mch_pkg::SUM_W'(span_x) + mch_pkg::SUM_W'(span_y)
                   + mch_pkg::SUM_W'(span_z);
        head_start = (r_state == S_HSTART);
        tsum       = $signed({2'b00, head}) + $signed({{2{r_decl[15]}}, r_decl});
        if (tsum < 0) begin
            twrap = tsum + 18'sd36000;
        end else if (tsum >= 18'sd36000) begin
            twrap = tsum - 18'sd36000;
        end else begin
            twrap = tsum;
        end
        out_free = !r_o_valid || i_ready;
        degen    = (span_x == '0) || (span_y == '0) || (span_z == '0);
        unique case (r_mode)
            mch_pkg::MODE_MEASURE: n_status = mch_pkg::ST_MEASURED;
            mch_pkg::MODE_CLEAR:   n_status = mch_pkg::ST_CLEARED;
            mch_pkg::MODE_SAMPLE:  n_status = mch_pkg::ST_SAMPLED;
            default: n_status = degen ? mch_pkg::ST_DONE_DEGEN : mch_pkg::ST_DONE;
        endcase
    end

    mch_lane u_lane_x (
        .i_clk, .i_rst_n, .i_ctrl(lane_ctrl), .i_src(r_x_src), .i_neg(r_inv[0]),
        .i_raw_x(i_sample_x), .i_raw_y(i_sample_y), .i_raw_z(i_sample_z),
        .i_span_sum(span_sum), .o_res(res_x), .o_span(span_x)
    );

    mch_lane u_lane_y (
        .i_clk, .i_rst_n, .i_ctrl(lane_ctrl), .i_src(r_y_src), .i_neg(r_inv[1]),
        .i_raw_x(i_sample_x), .i_raw_y(i_sample_y), .i_raw_z(i_sample_z),
        .i_span_sum(span_sum), .o_res(res_y), .o_span(span_y)
    );

    mch_lane u_lane_z (
        .i_clk, .i_rst_n, .i_ctrl(lane_ctrl), .i_src(r_z_src), .i_neg(r_inv[2]),
        .i_raw_x(i_sample_x), .i_raw_y(i_sample_y), .i_raw_z(i_sample_z),
        .i_span_sum(span_sum), .o_res(res_z), .o_span(span_z)
    );

    mch_heading u_heading (
        .i_clk, .i_rst_n, .i_start(head_start), .i_x(res_x), .i_y(res_y),
        .o_done(head_done), .o_heading(head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_src <= 2'd0;
            r_y_src <= 2'd1;
            r_z_src <= 2'd2;
            r_inv   <= 3'd0;
            r_decl  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mch_pkg::CFG_X_SOURCE:    r_x_src <= i_cfg_wdata[1:0];
                mch_pkg::CFG_Y_SOURCE:    r_y_src <= i_cfg_wdata[1:0];
                mch_pkg::CFG_Z_SOURCE:    r_z_src <= i_cfg_wdata[1:0];
                mch_pkg::CFG_INVERT_MASK: r_inv   <= i_cfg_wdata[2:0];
                mch_pkg::CFG_DECLINATION: r_decl  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cal_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode  <= mch_pkg::t_mode'(i_mode);
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    unique case (r_mode)
                        mch_pkg::MODE_MEASURE: r_state <= S_SCALE;
                        mch_pkg::MODE_FINISH:  r_state <= S_DSTART;
                        default: begin
                            r_cal_valid <= 1'b0;
                            r_state     <= S_OUT;
                        end
                    endcase
                end
                S_SCALE:  r_state <= S_HSTART;
                S_HSTART: r_state <= S_HEAD;
                S_HEAD: begin
                    if (head_done) begin
                        r_state <= S_TRUE;
                    end
                end
                S_TRUE: begin
                    r_true  <= twrap[15:0];
                    r_state <= S_OUT;
                end
                S_DSTART: begin
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dcnt == mch_pkg::DCNT_W'(mch_pkg::NUM_W - 1)) begin
                        r_state <= S_DEND;
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_DEND: begin
                    r_cal_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        if (r_mode == mch_pkg::MODE_MEASURE) begin
                            r_o_x    <= res_x;
                            r_o_y    <= res_y;
                            r_o_z    <= res_z;
                            r_o_mag  <= head;
                            r_o_true <= r_true;
                        end else begin
                            r_o_x    <= '0;
                            r_o_y    <= '0;
                            r_o_z    <= '0;
                            r_o_mag  <= '0;
                            r_o_true <= '0;
                        end
                        r_o_cal    <= r_cal_valid;
                        r_o_status <= n_status;
                        r_state    <= S_IDLE;
                    end else begin
                        if (r_o_valid && i_ready) begin
                            r_o_valid <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_out_x            = r_o_x;
    assign o_out_y            = r_o_y;
    assign o_out_z            = r_o_z;
    assign o_magnetic_heading = r_o_mag;
    assign o_true_heading     = r_o_true;
    assign o_is_calibrated    = r_o_cal;
    assign o_status           = r_o_status;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("A second transaction was accepted while one is in flight.");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_magnetic_heading < 16'd36000) && (o_true_heading < 16'd36000))
        else $error("Heading outside 0 to 35999.");

    a_status_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mch_pkg::ST_DONE || o_status == mch_pkg::ST_DONE_DEGEN))
        |-> o_is_calibrated)
        else $error("Finished calibration not flagged as calibrated.");

    a_status_uncal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mch_pkg::ST_CLEARED || o_status == mch_pkg::ST_SAMPLED))
        |-> !o_is_calibrated)
        else $error("Calibration still flagged after clear or sample.");

    a_head_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_done |-> (r_state == S_HEAD))
        else $error("Heading result arrived outside the heading wait.");

endmodule

// ===== dv/tb_magnetometer_calibrate_heading_unit.sv =====
module tb_magnetometer_calibrate_heading_unit;

    typedef struct {
        logic [1:0]         mode;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic               has_expect;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] ez;
        logic [15:0]        emag;
        logic [15:0]        etrue;
        logic               ecal;
        logic [2:0]         estatus;
    } t_row;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [15:0]        mag;
        logic [15:0]        tru;
        logic               cal;
        logic [2:0]         status;
    } t_heading_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_mode;
    logic signed [15:0] i_sample_x;
    logic signed [15:0] i_sample_y;
    logic signed [15:0] i_sample_z;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic signed [15:0] o_out_z;
    logic [15:0]        o_magnetic_heading;
    logic [15:0]        o_true_heading;
    logic               o_is_calibrated;
    logic [2:0]         o_status;
    logic               i_cfg_wr_en;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_wdata;

    magnetometer_calibrate_heading_unit uut (.*);

    logic [1:0]         src_sel [3];
    logic [2:0]         neg_mask;
    int                 declination;
    int                 axis_lo [3];
    int                 axis_hi [3];
    int                 iron_offset [3];
    int                 iron_scale [3];
    logic               cal_ok;

    t_heading_result    pending_results [$];
    t_row               directed_rows [$];
    int                 error_count;
    longint             cycle_count;
    logic               rx_stall_on;

    localparam longint CYCLE_LIMIT = 400000;

    const longint atan_tab [16] = '{18432000, 10881045, 5749245, 2918407, 1464867,
        733147, 366663, 183343, 91673, 45837, 22918, 11459, 5730, 2865, 1432, 716};

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic int heading_of(int xi, int yi);
        longint x, y, ang, xs, ys;
        x = longint'(xi) * 65536;
        y = longint'(yi) * 65536;
        ang = 0;
        if (xi == 0 && yi == 0) return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 73728000;
        end
        for (int i = 0; i < 16; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                ang += atan_tab[i];
            end else begin
                x = x - ys;
                y = y + xs;
                ang -= atan_tab[i];
            end
        end
        while (ang < 0) ang += 147456000;
        ang = (ang + 2048) / 4096;
        return int'(ang % 36000);
    endfunction

    function automatic int sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic void reset_calibration();
        for (int k = 0; k < 3; k++) begin
            axis_lo[k] = 32767;
            axis_hi[k] = -32768;
            iron_offset[k] = 0;
            iron_scale[k] = 4096;
        end
        cal_ok = 1'b0;
    endfunction

    function automatic t_heading_result predict_heading(logic [1:0] mode, int rx, int ry, int rz);
        t_heading_result r;
        int raw [3];
        int v [3];
        int res [3];
        int mag;
        int tru;
        longint span [3];
        longint sum;
        longint q;
        logic degen;
        raw = '{rx, ry, rz};
        res = '{0, 0, 0};
        mag = 0;
        tru = 0;
        for (int k = 0; k < 3; k++) begin
            v[k] = raw[(src_sel[k] > 2) ? 2 : src_sel[k]];
            if (neg_mask[k]) v[k] = (v[k] == -32768) ? 32767 : -v[k];
        end
        r.status = mch_pkg::ST_MEASURED;
        case (mch_pkg::t_mode'(mode))
            mch_pkg::MODE_MEASURE: begin
                for (int k = 0; k < 3; k++) begin
                    if (cal_ok) begin
                        q = (2 * longint'(v[k]) - iron_offset[k]) * longint'(iron_scale[k]);
                        res[k] = sat16(q / 8192);
                    end else begin
                        res[k] = v[k];
                    end
                end
                mag = heading_of(res[0], res[1]);
                tru = (mag + declination) % 36000;
                if (tru < 0) tru += 36000;
            end
            mch_pkg::MODE_CLEAR: begin
                reset_calibration();
                r.status = mch_pkg::ST_CLEARED;
            end
            mch_pkg::MODE_SAMPLE: begin
                for (int k = 0; k < 3; k++) begin
                    if (v[k] < axis_lo[k]) axis_lo[k] = v[k];
                    if (v[k] > axis_hi[k]) axis_hi[k] = v[k];
                end
                cal_ok = 1'b0;
                r.status = mch_pkg::ST_SAMPLED;
            end
            default: begin
                sum = 0;
                degen = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    span[k] = (axis_hi[k] > axis_lo[k]) ? axis_hi[k] - axis_lo[k] : 0;
                    sum += span[k];
                end
                for (int k = 0; k < 3; k++) begin
                    iron_offset[k] = (axis_hi[k] < axis_lo[k]) ? 0 : axis_lo[k] + axis_hi[k];
                    if (span[k] == 0) begin
                        iron_scale[k] = 4096;
                        degen = 1'b1;
                    end else begin
                        q = (sum << 12) / (3 * span[k]);
                        iron_scale[k] = (q > 65535) ? 65535 : int'(q);
                    end
                end
                cal_ok = 1'b1;
                r.status = degen ? mch_pkg::ST_DONE_DEGEN : mch_pkg::ST_DONE;
            end
        endcase
        r.x = 16'(res[0]);
        r.y = 16'(res[1]);
        r.z = 16'(res[2]);
        r.mag = 16'(mag);
        r.tru = 16'(tru);
        r.cal = cal_ok;
        return r;
    endfunction

    task automatic write_register(mch_pkg::t_cfg_index idx, logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            mch_pkg::CFG_X_SOURCE:    src_sel[0] = value[1:0];
            mch_pkg::CFG_Y_SOURCE:    src_sel[1] = value[1:0];
            mch_pkg::CFG_Z_SOURCE:    src_sel[2] = value[1:0];
            mch_pkg::CFG_INVERT_MASK: neg_mask = value[2:0];
            default:                  declination = int'(signed'(value));
        endcase
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [1:0] mode, logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        i_valid <= 1'b1;
        i_mode <= mode;
        i_sample_x <= x;
        i_sample_y <= y;
        i_sample_z <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(predict_heading(mode, x, y, z));
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [15:0] random_axis();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(0, 60)) - 30);
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_heading_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result status %0d", $time, o_status);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_x !== want.x || o_out_y !== want.y || o_out_z !== want.z ||
                        o_magnetic_heading !== want.mag || o_true_heading !== want.tru ||
                        o_is_calibrated !== want.cal || o_status !== want.status) begin
                        $display("%0t: expected %0d %0d %0d %0d %0d %0d %0d", $time,
                                 want.x, want.y, want.z, want.mag, want.tru, want.cal,
                                 want.status);
                        $display("%0t: actual   %0d %0d %0d %0d %0d %0d %0d", $time,
                                 o_out_x, o_out_y, o_out_z, o_magnetic_heading,
                                 o_true_heading, o_is_calibrated, o_status);
                        error_count++;
                    end
                end
            end
            if (rx_stall_on) i_ready <= ($urandom_range(0, 2) != 0);
            else i_ready <= 1'b1;
        end
    end

    function automatic t_row row(logic [1:0] m, int x, int y, int z);
        t_row r;
        r = '{default: '0};
        r.mode = m;
        r.sx = 16'(x);
        r.sy = 16'(y);
        r.sz = 16'(z);
        return r;
    endfunction

    function automatic t_row row_exp(logic [1:0] m, int x, int y, int z, int ex, int ey, int ez,
                                     int emag, int etrue, logic ecal, mch_pkg::t_status st);
        t_row r;
        r = row(m, x, y, z);
        r.has_expect = 1'b1;
        r.ex = 16'(ex);
        r.ey = 16'(ey);
        r.ez = 16'(ez);
        r.emag = 16'(emag);
        r.etrue = 16'(etrue);
        r.ecal = ecal;
        r.estatus = st;
        return r;
    endfunction

    initial begin
        t_heading_result want;
        int n_sent;
        error_count = 0;
        cycle_count = 0;
        rx_stall_on = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = mch_pkg::MODE_MEASURE;
        i_sample_x = '0;
        i_sample_y = '0;
        i_sample_z = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = mch_pkg::CFG_X_SOURCE;
        i_cfg_wdata = '0;
        src_sel = '{2'd0, 2'd1, 2'd2};
        neg_mask = '0;
        declination = 0;
        reset_calibration();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_rows.push_back(row_exp(mch_pkg::MODE_MEASURE, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                        mch_pkg::ST_MEASURED));
        directed_rows.push_back(row_exp(mch_pkg::MODE_MEASURE, 100, 0, 5, 100, 0, 5, 0, 0, 0,
                                        mch_pkg::ST_MEASURED));
        directed_rows.push_back(row_exp(mch_pkg::MODE_MEASURE, 0, 100, 0, 0, 100, 0, 9000, 9000,
                                        0, mch_pkg::ST_MEASURED));
        directed_rows.push_back(row_exp(mch_pkg::MODE_MEASURE, -100, 0, 0, -100, 0, 0, 18000,
                                        18000, 0, mch_pkg::ST_MEASURED));
        directed_rows.push_back(row(mch_pkg::MODE_MEASURE, 32767, -32768, -32768));
        directed_rows.push_back(row(mch_pkg::MODE_MEASURE, -32768, 32767, 32767));
        directed_rows.push_back(row_exp(mch_pkg::MODE_FINISH, 1, 2, 3, 0, 0, 0, 0, 0, 1,
                                        mch_pkg::ST_DONE_DEGEN));
        directed_rows.push_back(row(mch_pkg::MODE_MEASURE, 1000, -1000, 7));
        directed_rows.push_back(row_exp(mch_pkg::MODE_CLEAR, 9, 9, 9, 0, 0, 0, 0, 0, 0,
                                        mch_pkg::ST_CLEARED));
        directed_rows.push_back(row_exp(mch_pkg::MODE_SAMPLE, 500, 200, 50, 0, 0, 0, 0, 0, 0,
                                        mch_pkg::ST_SAMPLED));
        directed_rows.push_back(row_exp(mch_pkg::MODE_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                                        mch_pkg::ST_DONE_DEGEN));
        directed_rows.push_back(row(mch_pkg::MODE_MEASURE, 500, 200, 50));
        directed_rows.push_back(row_exp(mch_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                        mch_pkg::ST_CLEARED));
        directed_rows.push_back(row(mch_pkg::MODE_SAMPLE, -32768, -32768, -32768));
        directed_rows.push_back(row(mch_pkg::MODE_SAMPLE, 32767, 32767, 32767));
        directed_rows.push_back(row_exp(mch_pkg::MODE_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                                        mch_pkg::ST_DONE));
        directed_rows.push_back(row(mch_pkg::MODE_MEASURE, 32767, -32768, 0));
        directed_rows.push_back(row(mch_pkg::MODE_SAMPLE, -10, 400, 3));
        directed_rows.push_back(row(mch_pkg::MODE_SAMPLE, 10, -400, 5));
        directed_rows.push_back(row(mch_pkg::MODE_MEASURE, 3, 4, 5));
        directed_rows.push_back(row(mch_pkg::MODE_FINISH, 0, 0, 0));
        directed_rows.push_back(row(mch_pkg::MODE_MEASURE, 10, 0, -32768));
        directed_rows.push_back(row(mch_pkg::MODE_MEASURE, -5, -400, 32767));

        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].mode, directed_rows[i].sx, directed_rows[i].sy,
                        directed_rows[i].sz);
            if (directed_rows[i].has_expect) begin
                want = pending_results[$];
                if (want.x !== directed_rows[i].ex || want.y !== directed_rows[i].ey ||
                    want.z !== directed_rows[i].ez || want.mag !== directed_rows[i].emag ||
                    want.tru !== directed_rows[i].etrue || want.cal !== directed_rows[i].ecal ||
                    want.status !== directed_rows[i].estatus) begin
                    $display("%0t: expected status %0d heading %0d, actual status %0d heading %0d",
                             $time, directed_rows[i].estatus, directed_rows[i].emag,
                             want.status, want.mag);
                    error_count++;
                end
            end
        end
        i_valid <= 1'b0;
        drain_results();

        rx_stall_on = 1'b1;
        n_sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_register(mch_pkg::CFG_DECLINATION, 16'(18000));
                    write_register(mch_pkg::CFG_INVERT_MASK, 16'd7);
                end
                1: begin
                    write_register(mch_pkg::CFG_X_SOURCE, 16'd3);
                    write_register(mch_pkg::CFG_Y_SOURCE, 16'd0);
                    write_register(mch_pkg::CFG_Z_SOURCE, 16'd1);
                    write_register(mch_pkg::CFG_DECLINATION, 16'(-18000));
                end
                2: begin
                    write_register(mch_pkg::CFG_X_SOURCE, 16'd1);
                    write_register(mch_pkg::CFG_Y_SOURCE, 16'd2);
                    write_register(mch_pkg::CFG_Z_SOURCE, 16'd3);
                    write_register(mch_pkg::CFG_INVERT_MASK, 16'd2);
                    write_register(mch_pkg::CFG_DECLINATION, 16'h7fff);
                end
                3: begin
                    write_register(mch_pkg::CFG_INVERT_MASK, 16'd5);
                    write_register(mch_pkg::CFG_DECLINATION, 16'h8000);
                end
                4: begin
                    write_register(mch_pkg::CFG_X_SOURCE, 16'd0);
                    write_register(mch_pkg::CFG_Y_SOURCE, 16'd1);
                    write_register(mch_pkg::CFG_Z_SOURCE, 16'd2);
                    write_register(mch_pkg::CFG_INVERT_MASK, 16'd0);
                    write_register(mch_pkg::CFG_DECLINATION,
                                   16'($urandom_range(0, 36000) - 18000));
                end
                default: begin
                    rx_stall_on = 1'b0;
                    write_register(mch_pkg::CFG_INVERT_MASK, 16'($urandom_range(0, 7)));
                    write_register(mch_pkg::CFG_DECLINATION, 16'd0);
                end
            endcase
            repeat (27) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_sample(2'($urandom), random_axis(), random_axis(), random_axis());
                end else begin
                    send_sample(mch_pkg::MODE_CLEAR, random_axis(), random_axis(),
                                random_axis());
                    repeat ($urandom_range(1, 8)) begin
                        idle_gap();
                        send_sample(mch_pkg::MODE_SAMPLE, random_axis(), random_axis(),
                                    random_axis());
                    end
                    send_sample(mch_pkg::MODE_FINISH, random_axis(), random_axis(),
                                random_axis());
                    repeat ($urandom_range(1, 6)) begin
                        idle_gap();
                        send_sample(mch_pkg::MODE_MEASURE, random_axis(), random_axis(),
                                    random_axis());
                    end
                end
                n_sent++;
                if (n_sent == 100) begin
                    i_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
                idle_gap();
            end
            i_valid <= 1'b0;
            drain_results();
        end

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
